@@ hw/rtl/lbpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpc_pkg
// types, widths and reset values shared by the led channel controller
// ----------------------------------------------------------------------------
package lbpc_pkg;

    localparam int TIME_BITS  = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int LEVEL_W    = 8;

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [LEVEL_W-1:0]    t_level;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    typedef enum logic [2:0] {
        M_OFF    = 3'd0,
        M_ON     = 3'd1,
        M_DIM    = 3'd2,
        M_BRIGHT = 3'd3,
        M_BLINK  = 3'd4,
        M_BBLINK = 3'd5,
        M_DBLINK = 3'd6,
        M_PULSE  = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        P_OFF    = 2'd0,
        P_ON     = 2'd1,
        P_DIM    = 2'd2,
        P_BRIGHT = 2'd3
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        R_IS_PWM       = 3'd0,
        R_INVERTED     = 3'd1,
        R_BRIGHT_LEVEL = 3'd2,
        R_DIM_LEVEL    = 3'd3,
        R_ON_TICKS     = 3'd4,
        R_OFF_TICKS    = 3'd5
    } t_cfg_idx;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CMD  = 1'b1;

    localparam logic   RST_IS_PWM   = 1'b1;
    localparam logic   RST_INVERTED = 1'b0;
    localparam t_level RST_BRIGHT   = 8'd255;
    localparam t_level RST_DIM      = 8'd32;
    localparam t_time  RST_TICKS    = t_time'(500);
    localparam t_level LEVEL_MAX    = 8'd255;

endpackage

@@ hw/rtl/lbpc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbpc interfaces
// request, result and configuration channels of the led channel controller
// ----------------------------------------------------------------------------
interface lbpc_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [3:0] mode_code;

    modport source (output valid, output req_type, output mode_code, input ready);
    modport sink   (input valid, input req_type, input mode_code, output ready);
endinterface

interface lbpc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] drive_level;
    logic [1:0] lamp_phase;
    logic       status;

    modport source (output valid, output drive_level, output lamp_phase, output status,
                    input ready);
    modport sink   (input valid, input drive_level, input lamp_phase, input status,
                    output ready);
endinterface

interface lbpc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lbpc_pkg::CFG_IDX_W-1:0]  index;
    logic [lbpc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/led_blink_pulse_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_pulse_controller_core
// one led channel: mode commands and time ticks drive a level and phase
// ----------------------------------------------------------------------------
// a request word passes the input register, then the result register, before its result word is valid
// throughput: one word per cycle while result words are taken, set by the input and result registers
// a stalled result word holds the input register, so input ready follows result ready
// reset (synchronous, i_rst_n low): registers to defaults, mode and phase off,
// countdown = off_ticks, level = off level, error clear, both stages empty
module led_blink_pulse_controller_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbpc_req_if.sink   i_req,
    lbpc_rsp_if.source o_rsp,
    lbpc_cfg_if.sink   i_cfg
);
    import lbpc_pkg::*;

    // configuration
    logic   r_is_pwm, r_inverted;
    t_level r_bright, r_dim;
    t_time  r_on_ticks, r_off_ticks;

    // channel state
    t_mode  r_mode,  n_mode;
    t_phase r_phase, n_phase;
    t_time  r_count, n_count;
    t_level r_level, n_level;
    logic   r_error, n_error;

    // input register
    logic       r_in_valid;
    logic       r_in_type;
    logic [3:0] r_in_mode;

    // result register
    logic       r_out_valid;
    t_level     r_out_level;
    t_phase     r_out_phase;
    logic       r_out_status;

    logic       adv;
    logic       cfg_wr;
    t_cfg_idx   cfg_idx;
    t_level     cfg_lvl;
    t_mode      cmd_mode;
    t_phase     go_phase;
    logic       go_on_ticks;
    logic       go_en;
    t_level     lvl_off, lvl_on, lvl_bright, lvl_dim;

    assign adv        = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || adv;
    assign i_cfg.ready = 1'b1;
    assign cfg_wr     = i_cfg.valid && !r_error;
    assign cfg_idx    = t_cfg_idx'(i_cfg.index);
    assign cfg_lvl    = i_cfg.data[LEVEL_W-1:0];

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.drive_level = r_out_level;
    assign o_rsp.lamp_phase  = r_out_phase;
    assign o_rsp.status      = r_out_status;

    assign lvl_off    = {{(LEVEL_W-1){r_inverted && r_is_pwm}}, r_inverted};
    assign lvl_on     = {{(LEVEL_W-1){!r_inverted && r_is_pwm}}, !r_inverted};
    assign lvl_bright = r_inverted ? LEVEL_MAX - r_bright : r_bright;
    assign lvl_dim    = r_inverted ? LEVEL_MAX - r_dim : r_dim;

    // command folding for on/off leds
    always_comb begin
        cmd_mode = t_mode'(r_in_mode[2:0]);
        if (!r_is_pwm) begin
            unique case (t_mode'(r_in_mode[2:0]))
                M_BRIGHT:                    cmd_mode = M_ON;
                M_DIM:                       cmd_mode = M_OFF;
                M_BBLINK, M_DBLINK, M_PULSE: cmd_mode = M_BLINK;
                default: ;
            endcase
        end
    end

    // next phase selection
    always_comb begin
        go_en       = 1'b0;
        go_phase    = P_OFF;
        go_on_ticks = 1'b0;
        if (adv && !r_error) begin
            if (r_in_type == REQ_CMD) begin
                if (!r_in_mode[3]) begin
                    go_en = 1'b1;
                    unique case (cmd_mode)
                        M_OFF:    begin go_phase = P_OFF;    go_on_ticks = 1'b0; end
                        M_ON:     begin go_phase = P_ON;     go_on_ticks = 1'b1; end
                        M_DIM:    begin go_phase = P_DIM;    go_on_ticks = 1'b0; end
                        M_BRIGHT: begin go_phase = P_BRIGHT; go_on_ticks = 1'b1; end
                        M_BLINK: begin
                            if (r_phase == P_DIM || r_phase == P_OFF) begin
                                go_phase = P_ON;  go_on_ticks = 1'b1;
                            end else begin
                                go_phase = P_OFF; go_on_ticks = 1'b0;
                            end
                        end
                        M_BBLINK: begin
                            if (r_phase == P_BRIGHT) begin
                                go_phase = P_OFF;    go_on_ticks = 1'b0;
                            end else begin
                                go_phase = P_BRIGHT; go_on_ticks = 1'b1;
                            end
                        end
                        M_DBLINK: begin
                            if (r_phase == P_DIM) begin
                                go_phase = P_OFF; go_on_ticks = 1'b0;
                            end else begin
                                go_phase = P_DIM; go_on_ticks = 1'b1;
                            end
                        end
                        M_PULSE: begin
                            if (r_phase == P_DIM || r_phase == P_OFF) begin
                                go_phase = P_DIM;    go_on_ticks = 1'b0;
                            end else begin
                                go_phase = P_BRIGHT; go_on_ticks = 1'b1;
                            end
                        end
                        default: go_en = 1'b0;
                    endcase
                end
            end else if (r_mode[2] && r_count == '0) begin
                go_en = 1'b1;
                unique case (r_mode)
                    M_BLINK: begin
                        if (r_phase == P_ON) begin
                            go_phase = P_OFF; go_on_ticks = 1'b0;
                        end else begin
                            go_phase = P_ON;  go_on_ticks = 1'b1;
                        end
                    end
                    M_BBLINK: begin
                        if (r_phase == P_BRIGHT) begin
                            go_phase = P_OFF;    go_on_ticks = 1'b0;
                        end else begin
                            go_phase = P_BRIGHT; go_on_ticks = 1'b1;
                        end
                    end
                    M_DBLINK: begin
                        if (r_phase == P_DIM) begin
                            go_phase = P_OFF; go_on_ticks = 1'b0;
                        end else begin
                            go_phase = P_DIM; go_on_ticks = 1'b1;
                        end
                    end
                    default: begin
                        if (r_phase == P_BRIGHT) begin
                            go_phase = P_DIM;    go_on_ticks = 1'b0;
                        end else begin
                            go_phase = P_BRIGHT; go_on_ticks = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // state update
    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_count = r_count;
        n_level = r_level;
        n_error = r_error;
        if (adv && !r_error) begin
            if (r_in_type == REQ_CMD) begin
                if (r_in_mode[3]) begin
                    n_error = 1'b1;
                end else begin
                    n_mode = cmd_mode;
                end
            end else if (r_mode[2] && r_count != '0) begin
                n_count = r_count - t_time'(1);
            end
        end
        if (go_en) begin
            n_phase = go_phase;
            n_count = go_on_ticks ? r_on_ticks : r_off_ticks;
            unique case (go_phase)
                P_OFF:    n_level = lvl_off;
                P_ON:     n_level = lvl_on;
                P_DIM:    n_level = lvl_dim;
                P_BRIGHT: n_level = lvl_bright;
                default:  n_level = lvl_off;
            endcase
        end
        // level writes show at once in the matching phase
        if (cfg_wr && cfg_idx == R_BRIGHT_LEVEL && r_phase == P_BRIGHT) begin
            n_level = r_inverted ? LEVEL_MAX - cfg_lvl : cfg_lvl;
        end
        if (cfg_wr && cfg_idx == R_DIM_LEVEL && r_phase == P_DIM) begin
            n_level = r_inverted ? LEVEL_MAX - cfg_lvl : cfg_lvl;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_pwm    <= RST_IS_PWM;
            r_inverted  <= RST_INVERTED;
            r_bright    <= RST_BRIGHT;
            r_dim       <= RST_DIM;
            r_on_ticks  <= RST_TICKS;
            r_off_ticks <= RST_TICKS;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                R_IS_PWM:       r_is_pwm    <= i_cfg.data[0];
                R_INVERTED:     r_inverted  <= i_cfg.data[0];
                R_BRIGHT_LEVEL: r_bright    <= cfg_lvl;
                R_DIM_LEVEL:    r_dim       <= cfg_lvl;
                R_ON_TICKS:     r_on_ticks  <= t_time'(i_cfg.data);
                R_OFF_TICKS:    r_off_ticks <= t_time'(i_cfg.data);
                default: ;
            endcase
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_OFF;
            r_phase <= P_OFF;
            r_count <= RST_TICKS;
            r_level <= {{(LEVEL_W-1){RST_INVERTED && RST_IS_PWM}}, RST_INVERTED};
            r_error <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_count <= n_count;
            r_level <= n_level;
            r_error <= n_error;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_type <= i_req.req_type;
            r_in_mode <= i_req.mode_code;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_level  <= n_level;
            r_out_phase  <= n_phase;
            r_out_status <= n_error;
        end
    end

    // checks
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |=> r_error)
        else $error("error flag cleared without reset");

    a_error_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |=> ($stable(r_phase) && $stable(r_level) && $stable(r_count)))
        else $error("channel state changed while in error");

    a_steady_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_OFF && r_phase == P_OFF) || (r_mode == M_ON && r_phase == P_ON)
        || (r_mode == M_DIM && r_phase == P_DIM)
        || (r_mode == M_BRIGHT && r_phase == P_BRIGHT) || r_mode[2])
        else $error("steady mode with mismatched phase");

    a_status_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status) |-> r_error)
        else $error("error status reported without error flag");

endmodule
